>>> src/cfh_pkg.sv
package cfh_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_MIN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_MAX = 1'd1;

    localparam logic [15:0] POWER_MIN_RESET = 16'd1000;
    localparam logic [15:0] POWER_MAX_RESET = 16'd3600;

    // Reply codes.
    typedef enum logic [2:0] {
        REPLY_STATUS    = 3'd0,
        REPLY_OK        = 3'd1,
        REPLY_BAD_SUM   = 3'd2,
        REPLY_RANGE     = 3'd3,
        REPLY_UNKNOWN   = 3'd4,
        REPLY_RESET_OK  = 3'd5
    } reply_code_t;

    // Command letters.
    localparam logic [7:0] CMD_SET    = 8'h4C; // 'L'
    localparam logic [7:0] CMD_FORCE  = 8'h46; // 'F'
    localparam logic [7:0] CMD_STATUS = 8'h53; // 'S'
    localparam logic [7:0] CMD_RESET  = 8'h52; // 'R'

    // Status frame characters.
    localparam logic [7:0] CHAR_START  = 8'h24; // '$'
    localparam logic [7:0] CHAR_END    = 8'h23; // '#'
    localparam logic [7:0] CHAR_AUTO   = 8'h41; // 'A'
    localparam logic [7:0] CHAR_MANUAL = 8'h4D; // 'M'

    localparam int HDR_LEN    = 4;
    localparam int STATUS_LEN = 17;
    localparam int BEAT_W     = $clog2(STATUS_LEN);

    typedef logic [STATUS_LEN-1:0][7:0] status_frame_t;

endpackage

>>> src/cfh_if.sv
interface cfh_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  rx_byte;
    logic        frame_end;
    logic [7:0]  state_letter;
    logic        auto_mode;
    logic        pwm_on;
    logic [15:0] charge_power;
    logic [31:0] high_voltage_bits;
    logic [31:0] low_voltage_bits;
    logic [7:0]  fault_code;
    logic [31:0] now_ms;

    modport source (
        output valid, rx_byte, frame_end, state_letter, auto_mode, pwm_on,
               charge_power, high_voltage_bits, low_voltage_bits, fault_code, now_ms,
        input  ready
    );
    modport sink (
        input  valid, rx_byte, frame_end, state_letter, auto_mode, pwm_on,
               charge_power, high_voltage_bits, low_voltage_bits, fault_code, now_ms,
        output ready
    );
endinterface

interface cfh_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  reply_code;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic [15:0] setpoint_value;
    logic        power_forced;
    logic [31:0] command_time;

    modport source (
        output valid, reply_code, tx_byte, tx_last, setpoint_value, power_forced,
               command_time,
        input  ready
    );
    modport sink (
        input  valid, reply_code, tx_byte, tx_last, setpoint_value, power_forced,
               command_time,
        output ready
    );
endinterface

>>> src/cfh_status_frame.sv
module cfh_status_frame
    import cfh_pkg::*;
(
    input  logic [7:0]    state_letter,
    input  logic          auto_mode,
    input  logic          pwm_on,
    input  logic [15:0]   charge_power,
    input  logic [31:0]   high_voltage_bits,
    input  logic [31:0]   low_voltage_bits,
    input  logic [7:0]    fault_code,
    output status_frame_t frame
);

    logic [STATUS_LEN-1:0][7:0] body;
    logic [6:0][7:0]            pair_sum;
    logic [3:0][7:0]            quad_sum;
    logic [7:0]                 checksum;

    // Frame body, bytes 0 to 14.
    always_comb
    begin
        body      = '0;
        body[0]   = CHAR_START;
        body[1]   = state_letter;
        body[2]   = auto_mode ? CHAR_AUTO : CHAR_MANUAL;
        body[3]   = {7'd0, pwm_on};
        body[4]   = charge_power[15:8];
        body[5]   = charge_power[7:0];
        for (int i = 0; i < 4; i++)
        begin
            body[6 + i]  = high_voltage_bits[8*i +: 8];
            body[10 + i] = low_voltage_bits[8*i +: 8];
        end
        body[14]  = fault_code;
    end

    // Checksum over bytes 0 to 14 as an adder tree, modulo 256.
    always_comb
    begin
        for (int i = 0; i < 7; i++)
        begin
            pair_sum[i] = body[2*i] + body[2*i + 1];
        end
        for (int i = 0; i < 3; i++)
        begin
            quad_sum[i] = pair_sum[2*i] + pair_sum[2*i + 1];
        end
        quad_sum[3] = pair_sum[6] + body[14];
        checksum    = (quad_sum[0] + quad_sum[1]) + (quad_sum[2] + quad_sum[3]);
    end

    // Complete frame with checksum and end mark.
    always_comb
    begin
        frame     = body;
        frame[15] = checksum;
        frame[16] = CHAR_END;
    end

endmodule

>>> src/charger_command_frame_handler.sv
// The first result of a frame is registered and appears in the cycle after its closing byte is taken.
// Throughput: one byte per cycle while no result is pending or its last beat is being taken.
// A status request gives a 17-beat burst, one beat per ready cycle; input waits for its last.
// Reset (rst_n low, asynchronous) clears header bytes, counters, the stored setpoint,
// force flag and timestamp, and loads the power limits with 1000 and 3600.
module charger_command_frame_handler
    import cfh_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    cfh_in_if.sink               din,
    cfh_out_if.source            dout,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data
);

    logic [15:0]             power_min_reg;
    logic [15:0]             power_max_reg;
    logic [HDR_LEN-1:0][7:0] hdr_reg, hdr_next;
    logic [2:0]              count_reg, count_next;
    logic [15:0]             setpoint_reg, setpoint_next;
    logic                    force_reg, force_next;
    logic [31:0]             time_reg, time_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    burst_reg, burst_next;
    reply_code_t             code_reg, code_next;
    logic [BEAT_W-1:0]       beats_left_reg, beats_left_next;
    status_frame_t           msg_reg, msg_next;

    status_frame_t           status_frame;
    logic                    accept;
    logic                    take;
    logic                    out_last;
    logic [7:0]              sum_hdr;
    logic [15:0]             power;
    logic                    out_of_range;

    cfh_status_frame u_status (
        .state_letter      (din.state_letter),
        .auto_mode         (din.auto_mode),
        .pwm_on            (din.pwm_on),
        .charge_power      (din.charge_power),
        .high_voltage_bits (din.high_voltage_bits),
        .low_voltage_bits  (din.low_voltage_bits),
        .fault_code        (din.fault_code),
        .frame             (status_frame)
    );

    // Handshakes.
    assign out_last = (beats_left_reg == '0);
    assign take     = out_valid_reg && dout.ready;
    assign din.ready = !out_valid_reg || (dout.ready && out_last);
    assign accept   = din.valid && din.ready;

    // Header capture: the first four bytes of a frame overwrite the held ones.
    always_comb
    begin
        hdr_next   = hdr_reg;
        count_next = count_reg;
        if (accept)
        begin
            if (count_reg < 3'(HDR_LEN))
            begin
                hdr_next[count_reg[1:0]] = din.rx_byte;
                count_next = count_reg + 3'd1;
            end
            if (din.frame_end)
            begin
                count_next = '0;
            end
        end
    end

    // Checksum and power range check on the updated header.
    assign sum_hdr      = hdr_next[0] + hdr_next[1] + hdr_next[2];
    assign power        = {hdr_next[1], hdr_next[2]};
    assign out_of_range = ((power < power_min_reg) && (power != 16'd0))
                          || (power > power_max_reg);

    // Command decode and result loading.
    always_comb
    begin
        setpoint_next   = setpoint_reg;
        force_next      = force_reg;
        time_next       = time_reg;
        out_valid_next  = out_valid_reg;
        burst_next      = burst_reg;
        code_next       = code_reg;
        beats_left_next = beats_left_reg;
        msg_next        = msg_reg;

        // Drain the current result.
        if (take)
        begin
            if (out_last)
            begin
                out_valid_next = 1'b0;
            end
            else
            begin
                beats_left_next = beats_left_reg - 1'b1;
                msg_next        = {8'h00, msg_reg[STATUS_LEN-1:1]};
            end
        end

        // A closing byte loads a new result.
        if (accept && din.frame_end)
        begin
            out_valid_next  = 1'b1;
            burst_next      = 1'b0;
            beats_left_next = '0;
            if (sum_hdr != hdr_next[3])
            begin
                code_next = REPLY_BAD_SUM;
            end
            else
            begin
                case (hdr_next[0])
                    CMD_SET, CMD_FORCE:
                    begin
                        setpoint_next = power;
                        force_next    = (hdr_next[0] == CMD_FORCE);
                        if (out_of_range)
                        begin
                            time_next = '0;
                            code_next = REPLY_RANGE;
                        end
                        else
                        begin
                            time_next = din.now_ms;
                            code_next = REPLY_OK;
                        end
                    end
                    CMD_STATUS:
                    begin
                        code_next       = REPLY_STATUS;
                        burst_next      = 1'b1;
                        beats_left_next = BEAT_W'(STATUS_LEN - 1);
                        msg_next        = status_frame;
                    end
                    CMD_RESET:
                    begin
                        time_next = '0;
                        code_next = REPLY_RESET_OK;
                    end
                    default:
                    begin
                        time_next = '0;
                        code_next = REPLY_UNKNOWN;
                    end
                endcase
            end
        end
    end

    // Control and held state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            power_min_reg  <= POWER_MIN_RESET;
            power_max_reg  <= POWER_MAX_RESET;
            hdr_reg        <= '0;
            count_reg      <= '0;
            setpoint_reg   <= '0;
            force_reg      <= 1'b0;
            time_reg       <= '0;
            out_valid_reg  <= 1'b0;
            burst_reg      <= 1'b0;
            code_reg       <= REPLY_OK;
            beats_left_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_POWER_MIN: power_min_reg <= cfg_data;
                    CFG_POWER_MAX: power_max_reg <= cfg_data;
                    default:       power_max_reg <= power_max_reg;
                endcase
            end
            hdr_reg        <= hdr_next;
            count_reg      <= count_next;
            setpoint_reg   <= setpoint_next;
            force_reg      <= force_next;
            time_reg       <= time_next;
            out_valid_reg  <= out_valid_next;
            burst_reg      <= burst_next;
            code_reg       <= code_next;
            beats_left_reg <= beats_left_next;
        end
    end

    // Status frame bytes, shifted out one per beat.
    always_ff @(posedge clk)
    begin
        msg_reg <= msg_next;
    end

    // Result channel.
    assign dout.valid          = out_valid_reg;
    assign dout.reply_code     = burst_reg ? REPLY_STATUS : code_reg;
    assign dout.tx_byte        = burst_reg ? msg_reg[0] : 8'h00;
    assign dout.tx_last        = out_last;
    assign dout.setpoint_value = setpoint_reg;
    assign dout.power_forced   = force_reg;
    assign dout.command_time   = time_reg;

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import cfh_pkg::*;

    localparam int LIMIT_CYCLES = 100000;
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_REPORTS  = 10;

    // Fill modes for the status fields of a byte.
    localparam int FILL_RANDOM = 0;
    localparam int FILL_ZEROS  = 1;
    localparam int FILL_ONES   = 2;

    typedef struct packed {
        logic [7:0]  rx_byte;
        logic        frame_end;
        logic [7:0]  state_letter;
        logic        auto_mode;
        logic        pwm_on;
        logic [15:0] charge_power;
        logic [31:0] high_voltage_bits;
        logic [31:0] low_voltage_bits;
        logic [7:0]  fault_code;
        logic [31:0] now_ms;
    } rx_item_t;

    typedef struct packed {
        reply_code_t code;
        logic [7:0]  tx_byte;
        logic        tx_last;
        logic [15:0] setpoint;
        logic        force_flag;
        logic [31:0] cmd_time;
    } reply_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0] cfg_data;

    cfh_in_if  in_if ();
    cfh_out_if out_if ();

    charger_command_frame_handler u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .din       (in_if),
        .dout      (out_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Bytes waiting to be sent and replies waiting to arrive.
    rx_item_t byte_q[$];
    reply_t   reply_q[$];
    rx_item_t cur;

    // Shadow copy of the frame handler state and its limits.
    logic [7:0]  hdr [HDR_LEN];
    int          hdr_cnt;
    logic [15:0] held_power;
    logic        held_force;
    logic [31:0] held_stamp;
    logic [15:0] pmin = POWER_MIN_RESET;
    logic [15:0] pmax = POWER_MAX_RESET;

    int errors = 0;
    int cycles = 0;
    int hold_left = 0;
    logic hold_arm = 1'b0;
    logic hold_done = 1'b0;
    logic steady = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Queue one reply built from the shadow state.
    function automatic void push_reply(reply_code_t code, logic [7:0] tx, logic last);
        reply_t r;
        r.code = code;
        r.tx_byte = tx;
        r.tx_last = last;
        r.setpoint = held_power;
        r.force_flag = held_force;
        r.cmd_time = held_stamp;
        reply_q.push_back(r);
    endfunction

    // Work out the replies caused by one received byte.
    function automatic void predict_replies(rx_item_t it);
        logic [7:0]  msg [STATUS_LEN];
        logic [7:0]  sum;
        logic [15:0] p;
        if (hdr_cnt < HDR_LEN)
        begin
            hdr[hdr_cnt] = it.rx_byte;
            hdr_cnt++;
        end
        if (!it.frame_end)
            return;
        hdr_cnt = 0;
        sum = hdr[0] + hdr[1] + hdr[2];
        if (sum != hdr[3])
        begin
            push_reply(REPLY_BAD_SUM, 8'h00, 1'b1);
            return;
        end
        case (hdr[0])
            CMD_SET, CMD_FORCE:
            begin
                p = {hdr[1], hdr[2]};
                held_force = (hdr[0] == CMD_FORCE);
                held_power = p;
                held_stamp = it.now_ms;
                if ((p < pmin && p != 16'd0) || p > pmax)
                begin
                    held_stamp = 32'd0;
                    push_reply(REPLY_RANGE, 8'h00, 1'b1);
                end
                else
                    push_reply(REPLY_OK, 8'h00, 1'b1);
            end
            CMD_STATUS:
            begin
                msg[0] = CHAR_START;
                msg[1] = it.state_letter;
                msg[2] = it.auto_mode ? CHAR_AUTO : CHAR_MANUAL;
                msg[3] = {7'd0, it.pwm_on};
                msg[4] = it.charge_power[15:8];
                msg[5] = it.charge_power[7:0];
                for (int i = 0; i < 4; i++)
                begin
                    msg[6 + i] = it.high_voltage_bits[8*i +: 8];
                    msg[10 + i] = it.low_voltage_bits[8*i +: 8];
                end
                msg[14] = it.fault_code;
                sum = 8'd0;
                for (int i = 0; i < 15; i++)
                    sum += msg[i];
                msg[15] = sum;
                msg[16] = CHAR_END;
                for (int i = 0; i < STATUS_LEN; i++)
                    push_reply(REPLY_STATUS, msg[i], i == STATUS_LEN - 1);
            end
            CMD_RESET:
            begin
                held_stamp = 32'd0;
                push_reply(REPLY_RESET_OK, 8'h00, 1'b1);
            end
            default:
            begin
                held_stamp = 32'd0;
                push_reply(REPLY_UNKNOWN, 8'h00, 1'b1);
            end
        endcase
    endfunction

    function automatic void add_byte(logic [7:0] rx, logic fend, int fill);
        rx_item_t it;
        it.rx_byte = rx;
        it.frame_end = fend;
        if (fill == FILL_RANDOM)
        begin
            it.state_letter = 8'($urandom);
            it.auto_mode = 1'($urandom);
            it.pwm_on = 1'($urandom);
            it.charge_power = 16'($urandom);
            it.high_voltage_bits = $urandom;
            it.low_voltage_bits = $urandom;
            it.fault_code = 8'($urandom);
            it.now_ms = $urandom;
        end
        else
        begin
            {it.state_letter, it.auto_mode, it.pwm_on, it.charge_power, it.high_voltage_bits,
             it.low_voltage_bits, it.fault_code, it.now_ms} = (fill == FILL_ONES) ? '1 : '0;
        end
        byte_q.push_back(it);
    endfunction

    // A frame of len bytes whose header is cmd, power and its checksum.
    function automatic void add_frame(logic [7:0] cmd, logic [15:0] p, bit good, int len,
                                      int fill);
        logic [7:0] b [HDR_LEN];
        b[0] = cmd;
        b[1] = p[15:8];
        b[2] = p[7:0];
        b[3] = cmd + p[15:8] + p[7:0];
        if (!good)
            b[3] ^= 8'h01 << $urandom_range(7);
        for (int i = 0; i < len; i++)
            add_byte((i < HDR_LEN) ? b[i] : 8'($urandom), i == len - 1, fill);
    endfunction

    function automatic logic [15:0] pick_power();
        case ($urandom_range(6))
            0: return 16'd0;
            1: return pmin - 16'd1;
            2: return pmin;
            3: return pmax;
            4: return pmax + 16'd1;
            5: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly well formed commands, the rest noise of random length.
    function automatic void random_frame();
        logic [7:0] cmd;
        int len;
        if ($urandom_range(99) < 75)
        begin
            case ($urandom_range(9))
                0, 1, 2: cmd = CMD_SET;
                3, 4, 5: cmd = CMD_FORCE;
                6, 7:    cmd = CMD_STATUS;
                8:       cmd = CMD_RESET;
                default: cmd = 8'($urandom);
            endcase
            len = ($urandom_range(4) == 0) ? $urandom_range(5, 7) : HDR_LEN;
            add_frame(cmd, pick_power(), $urandom_range(9) != 0, len, FILL_RANDOM);
        end
        else
        begin
            len = $urandom_range(1, 7);
            for (int i = 0; i < len; i++)
                add_byte(8'($urandom), i == len - 1, FILL_RANDOM);
        end
    endfunction

    task automatic random_phase(int n_bytes);
        @(negedge clk);
        while (byte_q.size() < n_bytes)
            random_frame();
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == CFG_POWER_MIN)
            pmin = val;
        else
            pmax = val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Sender holds off until the block has drained every reply.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (byte_q.size() != 0 || in_if.valid || reply_q.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // Byte driver.
    always @(posedge clk)
    begin
        if (!rst_n)
            in_if.valid <= 1'b0;
        else if (!in_if.valid || in_if.ready)
        begin
            if (in_if.valid)
                predict_replies(cur);
            if (byte_q.size() != 0 && (steady || $urandom_range(99) >= 28))
            begin
                cur = byte_q.pop_front();
                in_if.valid <= 1'b1;
                in_if.rx_byte <= cur.rx_byte;
                in_if.frame_end <= cur.frame_end;
                in_if.state_letter <= cur.state_letter;
                in_if.auto_mode <= cur.auto_mode;
                in_if.pwm_on <= cur.pwm_on;
                in_if.charge_power <= cur.charge_power;
                in_if.high_voltage_bits <= cur.high_voltage_bits;
                in_if.low_voltage_bits <= cur.low_voltage_bits;
                in_if.fault_code <= cur.fault_code;
                in_if.now_ms <= cur.now_ms;
            end
            else
                in_if.valid <= 1'b0;
        end
    end

    // Long receiver hold-off, counted on its own.
    always @(posedge clk)
    begin
        if (hold_arm && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Reply monitor: checks each transaction against the oldest expected reply.
    always @(posedge clk)
    begin
        reply_t got;
        reply_t want;
        if (!rst_n)
            out_if.ready <= 1'b0;
        else
        begin
            if (out_if.valid && out_if.ready)
            begin
                got.code = reply_code_t'(out_if.reply_code);
                got.tx_byte = out_if.tx_byte;
                got.tx_last = out_if.tx_last;
                got.setpoint = out_if.setpoint_value;
                got.force_flag = out_if.power_forced;
                got.cmd_time = out_if.command_time;
                if (reply_q.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("tb: unexpected reply code=%0d tx=%h last=%b", got.code,
                                 got.tx_byte, got.tx_last);
                end
                else
                begin
                    want = reply_q.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display({"tb: mismatch exp code=%0d tx=%h last=%b sp=%0d f=%b",
                                      " t=%h | got code=%0d tx=%h last=%b sp=%0d f=%b t=%h"},
                                     want.code, want.tx_byte, want.tx_last, want.setpoint,
                                     want.force_flag, want.cmd_time, got.code, got.tx_byte,
                                     got.tx_last, got.setpoint, got.force_flag, got.cmd_time);
                    end
                end
            end
            out_if.ready <= (hold_left == 0) && (steady || $urandom_range(99) >= 28);
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_POWER_MIN;
        cfg_data = 16'd0;
        {in_if.valid, in_if.rx_byte, in_if.frame_end, in_if.state_letter, in_if.auto_mode,
         in_if.pwm_on, in_if.charge_power, in_if.high_voltage_bits, in_if.low_voltage_bits,
         in_if.fault_code, in_if.now_ms} = '0;
        out_if.ready = 1'b0;
        for (int i = 0; i < HDR_LEN; i++)
            hdr[i] = 8'd0;
        hdr_cnt = 0;
        held_power = 16'd0;
        held_force = 1'b0;
        held_stamp = 32'd0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed frames at the reset limits.
        @(negedge clk);
        add_frame(CMD_SET, 16'd2000, 1, 4, FILL_ZEROS);
        // Short frame keeping the old power low byte and checksum.
        add_frame(CMD_SET, 16'd2000, 1, 2, FILL_RANDOM);
        // Short frame with a new letter breaks the checksum.
        add_frame(CMD_FORCE, 16'd0, 1, 1, FILL_RANDOM);
        // Long frame, power far above the range.
        add_frame(CMD_FORCE, 16'hffff, 1, 6, FILL_ONES);
        add_frame(CMD_SET, 16'd0, 1, 4, FILL_RANDOM);
        add_frame(CMD_STATUS, 16'd0, 1, 4, FILL_ONES);
        add_frame(CMD_STATUS, 16'hffff, 1, 4, FILL_ZEROS);
        add_frame(CMD_RESET, 16'd1234, 1, 4, FILL_RANDOM);
        add_frame(8'h00, 16'd0, 1, 4, FILL_ZEROS);
        wait_idle();

        // Receiver stalls for a long time while status requests pile up.
        write_reg(CFG_POWER_MIN, 16'd500);
        write_reg(CFG_POWER_MAX, 16'd4000);
        @(negedge clk);
        hold_arm <= 1'b1;
        for (int i = 0; i < 3; i++)
            add_frame(CMD_STATUS, 16'd0, 1, 4, FILL_RANDOM);
        random_phase(25);
        wait_idle();

        // Widest range with no idling on either side.
        write_reg(CFG_POWER_MIN, 16'd0);
        write_reg(CFG_POWER_MAX, 16'hffff);
        @(negedge clk);
        steady <= 1'b1;
        random_phase(20);
        wait_idle();
        steady <= 1'b0;

        // Inverted range.
        write_reg(CFG_POWER_MIN, 16'hffff);
        write_reg(CFG_POWER_MAX, 16'd0);
        random_phase(20);
        wait_idle();

        // Single accepted nonzero power.
        write_reg(CFG_POWER_MIN, 16'h8000);
        write_reg(CFG_POWER_MAX, 16'h8000);
        random_phase(20);
        wait_idle();

        repeat (20) @(posedge clk);
        if (errors == 0 && reply_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> sim.f
src/cfh_pkg.sv
src/cfh_if.sv
src/cfh_status_frame.sv
src/charger_command_frame_handler.sv
verif/testbench.sv
